/* sv/ldl_pkg.sv */
// Shared types, codes and constants for the lazy deletion list table.
`default_nettype none

package ldl_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int VALUE_W       = 32;
   localparam int COUNT_W       = 5;

   localparam logic MODE_APPEND = 1'b0;
   localparam logic MODE_DELETE = 1'b1;

   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   typedef struct packed {
      logic                       mode;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               compacted;
      logic [COUNT_W-1:0] live_count;
      logic [COUNT_W-1:0] marked_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic match;
      logic apply;
      logic squeeze;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_squeeze;
      logic marked_zero;
   } sts_type;

endpackage

`default_nettype wire

/* sv/ldl_ctrl.sv */
// Sequencer for the lazy deletion list table: match, apply, squeeze, respond.
`default_nettype none

module ldl_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   output logic                 rsp_valid,
   output ldl_pkg::cmd_type     cmd,
   input  wire ldl_pkg::sts_type sts
);
   import ldl_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_APPLY,
      ST_SQUEEZE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd         = '0;
      cmd.load    = (state_ff == ST_IDLE) && start;
      cmd.match   = (state_ff == ST_MATCH);
      cmd.apply   = (state_ff == ST_APPLY);
      cmd.squeeze = (state_ff == ST_SQUEEZE) && !sts.marked_zero;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) state_ff <= ST_MATCH;
            end
            ST_MATCH: begin
               state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               if (sts.need_squeeze) begin
                  state_ff <= ST_SQUEEZE;
               end else begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_SQUEEZE: begin
               if (sts.marked_zero) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* sv/ldl_datapath.sv */
// Cell row, counters and result registers of the lazy deletion list table.
`default_nettype none

module ldl_datapath #(
   parameter int DEPTH = ldl_pkg::DEFAULT_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ldl_pkg::req_type req_item,
   input  wire ldl_pkg::cmd_type cmd,
   output ldl_pkg::sts_type      sts,
   output ldl_pkg::rsp_type      rsp_item
);
   import ldl_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   req_type                   req_ff, req_in;
   logic signed [VALUE_W-1:0] value_ff [DEPTH];
   logic signed [VALUE_W-1:0] value_in [DEPTH];
   logic [DEPTH-1:0]          live_ff, live_in;
   logic [DEPTH-1:0]          occ_ff, occ_in;
   logic [DEPTH-1:0]          hit_ff, hit_in;
   logic [CNT_W-1:0]          occ_count_ff, occ_count_in;
   logic [CNT_W-1:0]          live_cnt_ff, live_cnt_in;
   logic [CNT_W-1:0]          marked_ff, marked_in;
   logic [1:0]                status_ff, status_in;
   logic                      compacted_ff, compacted_in;

   logic [DEPTH-1:0] dead;
   logic [DEPTH-1:0] first_dead;
   logic [DEPTH-1:0] keep;
   logic [DEPTH-1:0] pick;
   logic             found;
   logic             full;
   logic [CNT_W-1:0] live_dec;
   logic [CNT_W-1:0] marked_inc;

   always_comb begin
      dead       = occ_ff & ~live_ff;
      first_dead = dead & (~dead + 1'b1);
      keep       = first_dead - 1'b1;
      pick       = hit_ff & (~hit_ff + 1'b1);
      found      = |hit_ff;
      full       = (occ_count_ff >= CNT_W'(DEPTH));
      live_dec   = live_cnt_ff - 1'b1;
      marked_inc = marked_ff + 1'b1;

      sts.need_squeeze = (req_ff.mode == MODE_DELETE) && found && (live_dec == marked_inc);
      sts.marked_zero  = (marked_ff == '0);

      req_in       = req_ff;
      value_in     = value_ff;
      live_in      = live_ff;
      occ_in       = occ_ff;
      hit_in       = hit_ff;
      occ_count_in = occ_count_ff;
      live_cnt_in  = live_cnt_ff;
      marked_in    = marked_ff;
      status_in    = status_ff;
      compacted_in = compacted_ff;

      if (cmd.load) req_in = req_item;

      if (cmd.match) begin
         for (int i = 0; i < DEPTH; i++) begin
            hit_in[i] = live_ff[i] && (value_ff[i] == req_ff.value);
         end
      end

      if (cmd.apply) begin
         compacted_in = 1'b0;
         status_in    = STATUS_DONE;
         if (req_ff.mode == MODE_APPEND) begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               for (int i = 0; i < DEPTH; i++) begin
                  if (occ_count_ff == CNT_W'(i)) begin
                     value_in[i] = req_ff.value;
                     live_in[i]  = 1'b1;
                     occ_in[i]   = 1'b1;
                  end
               end
               occ_count_in = occ_count_ff + 1'b1;
               live_cnt_in  = live_cnt_ff + 1'b1;
            end
         end else if (!found) begin
            status_in = STATUS_NO_MATCH;
         end else begin
            live_in      = live_ff & ~pick;
            live_cnt_in  = live_dec;
            marked_in    = marked_inc;
            compacted_in = sts.need_squeeze;
         end
      end

      // drop the oldest marked entry and shift everything above it down one
      if (cmd.squeeze) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (!keep[i]) begin
               value_in[i] = value_ff[i+1];
               live_in[i]  = live_ff[i+1];
               occ_in[i]   = occ_ff[i+1];
            end
         end
         if (!keep[DEPTH-1]) begin
            live_in[DEPTH-1] = 1'b0;
            occ_in[DEPTH-1]  = 1'b0;
         end
         occ_count_in = occ_count_ff - 1'b1;
         marked_in    = marked_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      value_ff <= value_in;
      hit_ff   <= hit_in;
      status_ff    <= status_in;
      compacted_ff <= compacted_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff      <= '0;
         occ_ff       <= '0;
         occ_count_ff <= '0;
         live_cnt_ff  <= '0;
         marked_ff    <= '0;
      end else begin
         live_ff      <= live_in;
         occ_ff       <= occ_in;
         occ_count_ff <= occ_count_in;
         live_cnt_ff  <= live_cnt_in;
         marked_ff    <= marked_in;
      end
   end

   always_comb begin
      rsp_item.status       = status_ff;
      rsp_item.compacted    = compacted_ff;
      rsp_item.live_count   = COUNT_W'(live_cnt_ff);
      rsp_item.marked_count = COUNT_W'(marked_ff);
   end

endmodule

`default_nettype wire

/* sv/lazy_deletion_list_table.sv */
// Top level of the lazy deletion list table: sequencer plus cell datapath.
// An accepted item passes through the match and apply states before its result is
//   strobed; a delete that triggers compaction also passes through the squeeze
//   state, one shift pass per marked entry, until no marked entry is left.
// The table takes no new item while busy, and busy holds until the result is strobed.
// Reset (synchronous, active high) empties the table and clears all counts;
//   results are strobed for one cycle and the receiver cannot stall them.
`default_nettype none

module lazy_deletion_list_table #(
   parameter int DEPTH = ldl_pkg::DEFAULT_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire ldl_pkg::req_type req_item,
   output logic                  rsp_valid,
   output ldl_pkg::rsp_type      rsp_item
);
   import ldl_pkg::*;

   // command and status between the sequencer and the datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: accept the item, step it through match and apply, hold
   // busy through compaction, then fire the result strobe
   ldl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath: row of cells with per-cell compare, lowest-index pick for
   // the oldest live match, and an in-place shift that squeezes out one
   // marked entry per cycle
   ldl_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_item (rsp_item)
   );

endmodule

`default_nettype wire

/* sv/ldl_checker.sv */
// Port-level checks of the lazy deletion list table, bound to the top level.
`default_nettype none

module ldl_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire ldl_pkg::rsp_type rsp_item
);
   import ldl_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted item");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result strobe right after accepting an item");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_compact_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.compacted) |->
         (rsp_item.marked_count == '0) && (rsp_item.status == STATUS_DONE))
      else $error("compaction left marked entries or bad status");

endmodule

bind lazy_deletion_list_table ldl_checker u_ldl_checker (.*);

`default_nettype wire
